>>> rtl/core/fccs_pkg.sv
`default_nettype none

package fccs_pkg;

    // Field and register widths
    localparam int unsigned REQ_W      = 2;
    localparam int unsigned CLUSTER_W  = 28;
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned SECTOR_W   = 32;
    localparam int unsigned SPC_W      = 14;
    localparam int unsigned SIC_W      = 13;
    localparam int unsigned LIMIT_W    = 29;
    localparam int unsigned STATUS_W   = 3;
    localparam int unsigned OFFSET_W   = 9;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;

    // FAT32 layout: 128 four-byte entries per 512-byte sector
    localparam int unsigned ENTRY_SHIFT = 7;
    localparam logic [SPC_W-1:0] SPC_MAX = SPC_W'(8192);

    // Depth of the queue between front and back
    localparam int unsigned QDEPTH = 2;
    localparam int unsigned PTR_W  = $clog2(QDEPTH);
    localparam int unsigned CNT_W  = $clog2(QDEPTH + 1);

    // Request codes on req_type
    localparam logic [REQ_W-1:0] REQ_OPEN  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_NEXT  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REPLY = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_DATA   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_LOOKUP = 3'd1;
    localparam logic [STATUS_W-1:0] ST_END    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ERROR  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OPENED = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FAT_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_BASE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPC       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT     = 2'd3;

    typedef enum logic [1:0] {
        OP_OPEN  = 2'd0,
        OP_NEXT  = 2'd1,
        OP_REPLY = 2'd2,
        OP_BAD   = 2'd3
    } op_t;

    // One classified request as it sits in the queue
    typedef struct packed {
        op_t                  op;
        logic [CLUSTER_W-1:0] start;
        logic [CLUSTER_W-1:0] next;
        logic                 failed;
    } item_t;

    typedef struct packed {
        logic [SECTOR_W-1:0] fat_base;
        logic [SECTOR_W-1:0] data_base;
        logic [SPC_W-1:0]    spc;
        logic [LIMIT_W-1:0]  limit;
    } cfg_t;

endpackage

`default_nettype wire

>>> rtl/core/fccs_front.sv
`default_nettype none

module fccs_front
    import fccs_pkg::*;
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_stall,
    input  wire [REQ_W-1:0]      req_type,
    input  wire [CLUSTER_W-1:0]  start_cluster,
    input  wire [WORD_W-1:0]     fat_word,
    input  wire                  fat_read_failed,
    output item_t                q_item,
    output logic                 q_valid,
    input  wire                  q_pop
);

    item_t             slot_reg [QDEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              push;
    item_t             item_in;

    always_comb
    begin
        item_in.start  = start_cluster;
        item_in.next   = fat_word[CLUSTER_W-1:0];
        item_in.failed = fat_read_failed;
        unique case (req_type)
            REQ_OPEN:  item_in.op = OP_OPEN;
            REQ_NEXT:  item_in.op = OP_NEXT;
            REQ_REPLY: item_in.op = OP_REPLY;
            default:   item_in.op = OP_BAD;
        endcase
    end

    assign in_stall = (count_reg == CNT_W'(QDEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != '0);
    assign q_item   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !q_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (q_pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/fccs_back.sv
`default_nettype none

module fccs_back
    import fccs_pkg::*;
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  cfg_t                 cfg,
    input  item_t                q_item,
    input  wire                  q_valid,
    output logic                 q_pop,
    output logic                 out_valid,
    input  wire                  out_stall,
    output logic [STATUS_W-1:0]  status,
    output logic [SECTOR_W-1:0]  sector_address,
    output logic [OFFSET_W-1:0]  fat_byte_offset,
    output logic                 fat_sector_load
);

    logic [CLUSTER_W-1:0] cur_reg;
    logic [CLUSTER_W-1:0] cur_next;
    logic [SIC_W-1:0]     sic_reg;
    logic [SIC_W-1:0]     sic_next;
    logic                 started_reg;
    logic                 started_next;
    logic                 await_reg;
    logic                 await_next;
    logic [SECTOR_W-1:0]  cached_reg;
    logic [SECTOR_W-1:0]  cached_next;
    logic                 cache_ok_reg;
    logic                 cache_ok_next;

    logic                 out_valid_reg;
    logic [STATUS_W-1:0]  status_reg;
    logic [SECTOR_W-1:0]  addr_reg;
    logic [OFFSET_W-1:0]  offset_reg;
    logic                 load_reg;

    logic [STATUS_W-1:0]  res_status;
    logic [SECTOR_W-1:0]  res_addr;
    logic [OFFSET_W-1:0]  res_offset;
    logic                 res_load;
    logic                 use_data;

    logic [SPC_W-1:0]               eff_spc;
    logic [CLUSTER_W-1:0]           mul_cluster;
    logic [SIC_W-1:0]               mul_idx;
    logic [CLUSTER_W+SPC_W-1:0]     product;
    logic [SECTOR_W-1:0]            data_addr;
    logic [SECTOR_W-1:0]            fat_sector;
    logic [SPC_W-1:0]               sic_inc;
    logic                           cur_ok;
    logic                           next_ok;

    function automatic logic cluster_ok(input logic [CLUSTER_W-1:0] c,
                                        input logic [LIMIT_W-1:0] lim);
        return (c >= CLUSTER_W'(2)) && ({1'b0, c} < lim);
    endfunction

    always_comb
    begin
        if (cfg.spc == '0)
        begin
            eff_spc = SPC_W'(1);
        end
        else if (cfg.spc > SPC_MAX)
        begin
            eff_spc = SPC_MAX;
        end
        else
        begin
            eff_spc = cfg.spc;
        end
    end

    assign cur_ok     = cluster_ok(cur_reg, cfg.limit);
    assign next_ok    = cluster_ok(q_item.next, cfg.limit);
    assign sic_inc    = {1'b0, sic_reg} + SPC_W'(1);
    assign fat_sector = cfg.fat_base + SECTOR_W'(cur_reg >> ENTRY_SHIFT);

    // Cluster two is the first data cluster, so the data area starts at (c - 2).
    assign product   = (CLUSTER_W+SPC_W)'(mul_cluster - CLUSTER_W'(2))
                       * (CLUSTER_W+SPC_W)'(eff_spc);
    assign data_addr = product[SECTOR_W-1:0] + cfg.data_base + SECTOR_W'(mul_idx);

    assign q_pop = q_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        cur_next      = cur_reg;
        sic_next      = sic_reg;
        started_next  = started_reg;
        await_next    = await_reg;
        cached_next   = cached_reg;
        cache_ok_next = cache_ok_reg;
        res_status    = ST_ERROR;
        res_offset    = '0;
        res_load      = 1'b0;
        use_data      = 1'b0;
        mul_cluster   = cur_reg;
        mul_idx       = sic_reg;

        unique case (q_item.op)
            OP_OPEN:
            begin
                cur_next     = q_item.start;
                sic_next     = '0;
                started_next = 1'b0;
                await_next   = 1'b0;
                res_status   = ST_OPENED;
            end
            OP_NEXT:
            begin
                if (await_reg)
                begin
                    res_status = ST_ERROR;
                end
                else if (cur_reg == '0)
                begin
                    res_status = ST_END;
                end
                else if (!cur_ok)
                begin
                    res_status = ST_ERROR;
                end
                else if (!started_reg)
                begin
                    started_next = 1'b1;
                    sic_next     = '0;
                    mul_idx      = '0;
                    use_data     = 1'b1;
                    res_status   = ST_DATA;
                end
                else if (sic_inc < eff_spc)
                begin
                    sic_next   = sic_inc[SIC_W-1:0];
                    mul_idx    = sic_inc[SIC_W-1:0];
                    use_data   = 1'b1;
                    res_status = ST_DATA;
                end
                else
                begin
                    // Cluster boundary: ask for the FAT entry of the current cluster.
                    res_status = ST_LOOKUP;
                    res_offset = {cur_reg[ENTRY_SHIFT-1:0], 2'b00};
                    res_load   = !(cache_ok_reg && (cached_reg == fat_sector));
                    await_next = 1'b1;
                    if (res_load)
                    begin
                        cached_next   = fat_sector;
                        cache_ok_next = 1'b0;
                    end
                end
            end
            OP_REPLY:
            begin
                if (!await_reg)
                begin
                    res_status = ST_ERROR;
                end
                else if (q_item.failed)
                begin
                    await_next    = 1'b0;
                    cache_ok_next = 1'b0;
                    res_status    = ST_ERROR;
                end
                else
                begin
                    await_next    = 1'b0;
                    cache_ok_next = 1'b1;
                    sic_next      = '0;
                    if (next_ok)
                    begin
                        cur_next    = q_item.next;
                        mul_cluster = q_item.next;
                        mul_idx     = '0;
                        use_data    = 1'b1;
                        res_status  = ST_DATA;
                    end
                    else
                    begin
                        cur_next   = '0;
                        res_status = ST_END;
                    end
                end
            end
            default:
            begin
                res_status = ST_ERROR;
            end
        endcase

        res_addr = '0;
        if (use_data)
        begin
            res_addr = data_addr;
        end
        else if (res_status == ST_LOOKUP)
        begin
            res_addr = fat_sector;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg       <= '0;
            sic_reg       <= '0;
            started_reg   <= 1'b0;
            await_reg     <= 1'b0;
            cached_reg    <= '0;
            cache_ok_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                cur_reg       <= cur_next;
                sic_reg       <= sic_next;
                started_reg   <= started_next;
                await_reg     <= await_next;
                cached_reg    <= cached_next;
                cache_ok_reg  <= cache_ok_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            status_reg <= res_status;
            addr_reg   <= res_addr;
            offset_reg <= res_offset;
            load_reg   <= res_load;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign sector_address  = addr_reg;
    assign fat_byte_offset = offset_reg;
    assign fat_sector_load = load_reg;

endmodule

`default_nettype wire

>>> rtl/core/fat32_cluster_chain_sequencer.sv
// FAT32 cluster chain sequencer. Open an object with its start cluster, then send one
// "next" request per data sector wanted; each result is either the absolute data sector,
// a FAT lookup (FAT sector, entry byte offset, and a load flag when that sector is not
// the cached one) that must be answered by a reply beat carrying the raw FAT entry, end
// of chain, an error, or the acknowledgement of an open. Every request beat yields
// exactly one result beat. The block takes one beat per cycle while in_stall is low;
// requests enter a two-entry queue and the execution stage retires one per cycle unless
// out_stall holds its result, computing the data sector with a single 28x14 multiply in
// that stage. A request beat is written into a queue slot; its result is registered
// in the output register when popped. in_stall rises only when the queue is full, which
// happens while the result side holds out_stall. Users must write configuration registers
// through cfg_we/cfg_index/cfg_data only while no request is in flight (not enforced).
`default_nettype none

module fat32_cluster_chain_sequencer
    import fccs_pkg::*;
(
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   cfg_we,
    input  wire [CFG_IDX_W-1:0]   cfg_index,
    input  wire [CFG_DATA_W-1:0]  cfg_data,
    input  wire                   in_valid,
    output logic                  in_stall,
    input  wire [REQ_W-1:0]       req_type,
    input  wire [CLUSTER_W-1:0]   start_cluster,
    input  wire [WORD_W-1:0]      fat_word,
    input  wire                   fat_read_failed,
    output logic                  out_valid,
    input  wire                   out_stall,
    output logic [STATUS_W-1:0]   status,
    output logic [SECTOR_W-1:0]   sector_address,
    output logic [OFFSET_W-1:0]   fat_byte_offset,
    output logic                  fat_sector_load
);

    cfg_t  cfg_reg;
    item_t q_item;
    logic  q_valid;
    logic  q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fat_base  <= '0;
            cfg_reg.data_base <= '0;
            cfg_reg.spc       <= SPC_W'(1);
            cfg_reg.limit     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FAT_BASE:  cfg_reg.fat_base  <= cfg_data[SECTOR_W-1:0];
                CFG_DATA_BASE: cfg_reg.data_base <= cfg_data[SECTOR_W-1:0];
                CFG_SPC:       cfg_reg.spc       <= cfg_data[SPC_W-1:0];
                CFG_LIMIT:     cfg_reg.limit     <= cfg_data[LIMIT_W-1:0];
                default:       cfg_reg           <= cfg_reg;
            endcase
        end
    end

    fccs_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .req_type        (req_type),
        .start_cluster   (start_cluster),
        .fat_word        (fat_word),
        .fat_read_failed (fat_read_failed),
        .q_item          (q_item),
        .q_valid         (q_valid),
        .q_pop           (q_pop)
    );

    fccs_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .q_item          (q_item),
        .q_valid         (q_valid),
        .q_pop           (q_pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .sector_address  (sector_address),
        .fat_byte_offset (fat_byte_offset),
        .fat_sector_load (fat_sector_load)
    );

endmodule

`default_nettype wire

>>> rtl/core/fccs_checker.sv
`default_nettype none

module fccs_checker
    import fccs_pkg::*;
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  out_valid,
    input  wire                  out_stall,
    input  wire [STATUS_W-1:0]   status,
    input  wire [SECTOR_W-1:0]   sector_address,
    input  wire [OFFSET_W-1:0]   fat_byte_offset,
    input  wire                  fat_sector_load
);

    // A stalled result beat stays in place.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(sector_address)
            && $stable(fat_byte_offset) && $stable(fat_sector_load))
        else $error("result beat changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_DATA) || (status == ST_LOOKUP) || (status == ST_END)
            || (status == ST_ERROR) || (status == ST_OPENED))
        else $error("status outside the defined codes");

    // Only a FAT lookup carries an offset or a load flag, and its offset is entry aligned.
    a_lookup_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_LOOKUP) |-> (fat_byte_offset == '0) && !fat_sector_load)
        else $error("lookup fields set on a non-lookup result");

    a_lookup_align: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_LOOKUP) |-> (fat_byte_offset[1:0] == 2'b00))
        else $error("FAT entry offset not word aligned");

    a_no_address: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((status == ST_END) || (status == ST_ERROR) || (status == ST_OPENED))
            |-> (sector_address == '0))
        else $error("address present on a result without one");

endmodule

bind fat32_cluster_chain_sequencer fccs_checker u_fccs_checker (.*);

`default_nettype wire

>>> tb/chain_check_pkg.sv
`timescale 1ns / 100ps

package chain_check_pkg;

    import fccs_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SECTOR_W-1:0] sector;
        logic [OFFSET_W-1:0] offset;
        logic                load;
    } sector_result_t;

    class chain_scoreboard;

        logic [SECTOR_W-1:0]  fat_base  = '0;
        logic [SECTOR_W-1:0]  data_base = '0;
        logic [SPC_W-1:0]     spc       = SPC_W'(1);
        logic [LIMIT_W-1:0]   limit     = '0;

        logic [CLUSTER_W-1:0] cluster       = '0;
        logic [SIC_W-1:0]     sector_idx    = '0;
        bit                   started       = 1'b0;
        bit                   waiting       = 1'b0;
        logic [SECTOR_W-1:0]  cached_sector = '0;
        bit                   cache_valid   = 1'b0;

        sector_result_t expected_sectors[$];
        int unsigned    failures = 0;

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_FAT_BASE:  fat_base  = value;
                CFG_DATA_BASE: data_base = value;
                CFG_SPC:       spc       = value[SPC_W-1:0];
                CFG_LIMIT:     limit     = value[LIMIT_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned eff_spc();
            if (spc == '0)
                return 1;
            if (spc > SPC_MAX)
                return 32'(SPC_MAX);
            return 32'(spc);
        endfunction

        function bit valid_cluster(logic [CLUSTER_W-1:0] c);
            return (32'(c) >= 2) && (32'(c) < 32'(limit));
        endfunction

        function logic [SECTOR_W-1:0] data_sector(logic [CLUSTER_W-1:0] c,
                                                 logic [SIC_W-1:0] idx);
            logic [63:0] addr;
            addr = 64'(c - CLUSTER_W'(2)) * 64'(eff_spc()) + 64'(data_base) + 64'(idx);
            return addr[SECTOR_W-1:0];
        endfunction

        function sector_result_t walk_chain(logic [REQ_W-1:0] req,
                                            logic [CLUSTER_W-1:0] start,
                                            logic [WORD_W-1:0] word,
                                            logic failed);
            sector_result_t r;
            logic [CLUSTER_W-1:0] nxt;
            logic [SECTOR_W-1:0] fsec;
            r = '0;
            r.status = ST_ERROR;
            case (op_t'(req))
                OP_OPEN: begin
                    cluster    = start;
                    sector_idx = '0;
                    started    = 1'b0;
                    waiting    = 1'b0;
                    r.status   = ST_OPENED;
                end
                OP_NEXT: begin
                    if (waiting)
                        r.status = ST_ERROR;
                    else if (cluster == '0)
                        r.status = ST_END;
                    else if (!valid_cluster(cluster))
                        r.status = ST_ERROR;
                    else if (!started) begin
                        started    = 1'b1;
                        sector_idx = '0;
                        r.status   = ST_DATA;
                        r.sector   = data_sector(cluster, sector_idx);
                    end else if (32'(sector_idx) + 1 < eff_spc()) begin
                        sector_idx = sector_idx + 1'b1;
                        r.status   = ST_DATA;
                        r.sector   = data_sector(cluster, sector_idx);
                    end else begin
                        // Cluster boundary: ask for the FAT entry of the current cluster.
                        fsec     = fat_base + SECTOR_W'(cluster >> ENTRY_SHIFT);
                        r.status = ST_LOOKUP;
                        r.sector = fsec;
                        r.offset = {cluster[ENTRY_SHIFT-1:0], 2'b00};
                        r.load   = !(cache_valid && cached_sector == fsec);
                        if (r.load) begin
                            cached_sector = fsec;
                            cache_valid   = 1'b0;
                        end
                        waiting = 1'b1;
                    end
                end
                OP_REPLY: begin
                    if (waiting) begin
                        waiting = 1'b0;
                        if (failed) begin
                            cache_valid = 1'b0;
                            r.status    = ST_ERROR;
                        end else begin
                            cache_valid = 1'b1;
                            nxt         = word[CLUSTER_W-1:0];
                            sector_idx  = '0;
                            if (valid_cluster(nxt)) begin
                                cluster  = nxt;
                                r.status = ST_DATA;
                                r.sector = data_sector(cluster, sector_idx);
                            end else begin
                                cluster  = '0;
                                r.status = ST_END;
                            end
                        end
                    end
                end
                default: r.status = ST_ERROR;
            endcase
            return r;
        endfunction

        function void note_request(logic [REQ_W-1:0] req, logic [CLUSTER_W-1:0] start,
                                   logic [WORD_W-1:0] word, logic failed);
            expected_sectors.push_back(walk_chain(req, start, word, failed));
        endfunction

        function int unsigned pending();
            return expected_sectors.size();
        endfunction

        function void report(string msg);
            failures++;
            if (failures <= 10)
                $display("%0t ns: %s", $realtime, msg);
        endfunction

        function void check_result(logic [STATUS_W-1:0] status, logic [SECTOR_W-1:0] sector,
                                   logic [OFFSET_W-1:0] offset, logic load);
            sector_result_t want;
            if (expected_sectors.size() == 0) begin
                report($sformatf("unexpected beat: status %0d sector %h offset %0d load %0d",
                                 status, sector, offset, load));
                return;
            end
            want = expected_sectors.pop_front();
            if (status !== want.status || sector !== want.sector ||
                offset !== want.offset || load !== want.load)
                report($sformatf({"expected status %0d sector %h offset %0d load %0d, ",
                                  "got status %0d sector %h offset %0d load %0d"},
                                 want.status, want.sector, want.offset, want.load,
                                 status, sector, offset, load));
        endfunction

    endclass

endpackage

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

    import fccs_pkg::*;
    import chain_check_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [REQ_W-1:0]      req_type;
    logic [CLUSTER_W-1:0]  start_cluster;
    logic [WORD_W-1:0]     fat_word;
    logic                  fat_read_failed;
    logic                  out_valid;
    logic                  out_stall;
    logic [STATUS_W-1:0]   status;
    logic [SECTOR_W-1:0]   sector_address;
    logic [OFFSET_W-1:0]   fat_byte_offset;
    logic                  fat_sector_load;

    chain_scoreboard sb = new();

    int          sender_idle_pct    = 0;
    int          receiver_stall_pct = 0;
    int          holdoff_cycles     = 0;
    int unsigned cycles             = 0;

    fat32_cluster_chain_sequencer uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .req_type        (req_type),
        .start_cluster   (start_cluster),
        .fat_word        (fat_word),
        .fat_read_failed (fat_read_failed),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .sector_address  (sector_address),
        .fat_byte_offset (fat_byte_offset),
        .fat_sector_load (fat_sector_load)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles == CYCLE_LIMIT)
            begin
                $display("fat32_cluster_chain_sequencer: mismatch");
                $finish;
            end
        end
    end

    // Result side: checks every accepted beat and decides the stall for the next edge.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && !out_stall)
                sb.check_result(status, sector_address, fat_byte_offset, fat_sector_load);
            if (holdoff_cycles > 0)
            begin
                holdoff_cycles--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    task automatic send(op_t op, logic [CLUSTER_W-1:0] start, logic [WORD_W-1:0] word,
                        logic failed);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        req_type        <= op;
        start_cluster   <= start;
        fat_word        <= word;
        fat_read_failed <= failed;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_request(op, start, word, failed);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        sb.set_reg(idx, value);
        @(posedge clk);
    endtask

    task automatic write_config(logic [31:0] fat_base, logic [31:0] data_base,
                                logic [31:0] spc, logic [31:0] lim);
        write_reg(CFG_FAT_BASE, fat_base);
        write_reg(CFG_DATA_BASE, data_base);
        write_reg(CFG_SPC, spc);
        write_reg(CFG_LIMIT, lim);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly valid clusters, with a bias toward the following cluster so that
    // consecutive lookups often land in the cached FAT sector.
    function automatic logic [CLUSTER_W-1:0] pick_cluster();
        int unsigned span;
        int unsigned roll;
        span = (32'(sb.limit) > (32'd1 << CLUSTER_W)) ? (32'd1 << CLUSTER_W) : 32'(sb.limit);
        roll = $urandom_range(99);
        if (roll < 6)
            return CLUSTER_W'($urandom);
        if (roll < 9 || span <= 2)
            return CLUSTER_W'($urandom_range(2));
        if (roll < 45 && sb.valid_cluster(sb.cluster + 1'b1))
            return sb.cluster + 1'b1;
        if (roll < 50)
            return CLUSTER_W'(span - 1);
        return CLUSTER_W'($urandom_range(span - 1, 2));
    endfunction

    task automatic run_phase(logic [31:0] fat_base, logic [31:0] data_base, logic [31:0] spc,
                             logic [31:0] lim, int count, int idle, int stall, bit squeeze);
        int unsigned          roll;
        int unsigned          kind;
        logic [CLUSTER_W-1:0] nxt;
        logic [WORD_W-1:0]    word;
        drain();
        write_config(fat_base, data_base, spc, lim);
        sender_idle_pct    = idle;
        receiver_stall_pct = stall;
        for (int i = 0; i < count; i++)
        begin
            // A long hold-off on the result side lets the queue fill and stall the input.
            if (squeeze && i == count / 3)
                holdoff_cycles = 60;
            if (squeeze && i == 2 * count / 3)
                drain();
            kind = $urandom_range(99);
            if (kind < 70)
                nxt = pick_cluster();
            else if (kind < 80)
                nxt = CLUSTER_W'(28'hFFFFFF8 | $urandom_range(7));
            else if (kind < 88)
                nxt = CLUSTER_W'(sb.limit);
            else if (kind < 94)
                nxt = CLUSTER_W'($urandom_range(1));
            else
                nxt = CLUSTER_W'($urandom);
            word = {4'($urandom), nxt};
            roll = $urandom_range(99);
            if (sb.waiting)
            begin
                if (roll < 86)
                    send(OP_REPLY, CLUSTER_W'($urandom), word, $urandom_range(9) == 0);
                else if (roll < 93)
                    send(OP_NEXT, CLUSTER_W'($urandom), $urandom, 1'($urandom_range(1)));
                else if (roll < 97)
                    send(OP_OPEN, pick_cluster(), $urandom, 1'($urandom_range(1)));
                else
                    send(OP_BAD, CLUSTER_W'($urandom), $urandom, 1'($urandom_range(1)));
            end
            else if (!sb.valid_cluster(sb.cluster) && roll < 80)
                send(OP_OPEN, pick_cluster(), $urandom, 1'($urandom_range(1)));
            else if (roll < 86)
                send(OP_NEXT, CLUSTER_W'($urandom), $urandom, 1'($urandom_range(1)));
            else if (roll < 93)
                send(OP_OPEN, pick_cluster(), $urandom, 1'($urandom_range(1)));
            else if (roll < 97)
                send(OP_REPLY, CLUSTER_W'($urandom), word, 1'($urandom_range(1)));
            else
                send(OP_BAD, CLUSTER_W'($urandom), $urandom, 1'($urandom_range(1)));
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        in_valid        = 1'b0;
        req_type        = '0;
        start_cluster   = '0;
        fat_word        = '0;
        fat_read_failed = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_config(32'h100, 32'h2000, 32'd2, 32'd300);
        send(OP_NEXT, '0, '0, 1'b0);
        send(OP_REPLY, '0, 32'd7, 1'b0);
        send(OP_BAD, '0, '0, 1'b0);
        send(OP_OPEN, CLUSTER_W'(1), '0, 1'b0);
        send(OP_NEXT, '0, '0, 1'b0);
        send(OP_OPEN, CLUSTER_W'(300), '0, 1'b0);
        send(OP_NEXT, '0, '0, 1'b0);
        send(OP_OPEN, '1, '0, 1'b0);
        send(OP_NEXT, '0, '0, 1'b0);
        send(OP_OPEN, CLUSTER_W'(299), '0, 1'b0);
        send(OP_NEXT, '0, '0, 1'b0);
        send(OP_NEXT, '0, '0, 1'b0);
        send(OP_NEXT, '0, '0, 1'b0);
        send(OP_NEXT, '0, '0, 1'b0);
        send(OP_REPLY, '0, 32'd5, 1'b1);
        send(OP_NEXT, '0, '0, 1'b0);
        send(OP_REPLY, '0, 32'hF000_0005, 1'b0);
        send(OP_NEXT, '0, '0, 1'b0);
        send(OP_NEXT, '0, '0, 1'b0);
        send(OP_OPEN, CLUSTER_W'(2), '0, 1'b0);
        send(OP_NEXT, '0, '0, 1'b0);
        send(OP_NEXT, '0, '0, 1'b0);
        send(OP_NEXT, '0, '0, 1'b0);
        send(OP_REPLY, '0, 32'hFFFF_FFFF, 1'b0);
        send(OP_NEXT, '0, '0, 1'b0);

        run_phase(32'h0003_0000, 32'h1000_0000, 32'd4, 32'd1200, 250, 0, 0, 1'b1);
        run_phase(32'hFFFF_FFFF, 32'hFFFF_FFF0, 32'd0, 32'hFFFF_FFFF, 250, 63, 0, 1'b0);
        run_phase(32'h1234_5678, 32'h8000_0000, 32'd3, 32'h1000_0000, 250, 0, 63, 1'b0);
        run_phase(32'h0, 32'h0, 32'd16383, 32'd1000, 60, 15, 15, 1'b0);
        run_phase(32'h40, 32'hFFFF_0000, 32'd1, 32'd3, 180, 15, 15, 1'b1);
        run_phase(32'h7, 32'h100, 32'd8192, 32'h1000_0000, 60, 0, 0, 1'b0);

        drain();
        repeat (8) @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("fat32_cluster_chain_sequencer: match");
        else
            $display("fat32_cluster_chain_sequencer: mismatch");
        $finish;
    end

endmodule
